// ===== hdl/svpwm_pkg.sv =====
// Shared constants and types for the space vector PWM timing unit.
package svpwm_pkg;

	localparam int VECTOR_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF  = 16;
	localparam int HALF_PERIOD_RST  = 4200;

	localparam int KFRAC           = 20;
	localparam int INV_SQRT3_K     = 605396;
	localparam int TWO_INV_SQRT3_K = 1210791;
	localparam int STAGES          = 6;

	typedef enum logic [2:0] {
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5,
		SEC_6 = 3'd6
	} sector_t;

	typedef struct packed {
		logic early;
		logic late;
	} stage_adv_t;

endpackage

// ===== hdl/svpwm_ifs.sv =====
// Channel interfaces: modulation vector in, compare values out, half-period write.
interface svpwm_vec_if #(parameter int VECTOR_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [VECTOR_WIDTH-1:0] alpha;
	logic signed [VECTOR_WIDTH-1:0] beta;

	modport source (output valid, output alpha, output beta, input ready);
	modport sink   (input valid, input alpha, input beta, output ready);
endinterface

interface svpwm_time_if #(parameter int COUNT_WIDTH = 16);
	logic                   valid;
	logic                   ready;
	logic [COUNT_WIDTH-1:0] time_a;
	logic [COUNT_WIDTH-1:0] time_b;
	logic [COUNT_WIDTH-1:0] time_c;
	logic [2:0]             sector;

	modport source (output valid, output time_a, output time_b, output time_c,
		output sector, input ready);
	modport sink   (input valid, input time_a, input time_b, input time_c,
		input sector, output ready);
endinterface

interface svpwm_cfg_if #(parameter int COUNT_WIDTH = 16);
	logic                   valid;
	logic                   ready;
	logic [COUNT_WIDTH-1:0] half_period;

	modport source (output valid, output half_period, input ready);
	modport sink   (input valid, input half_period, output ready);
endinterface

// ===== hdl/svpwm_sector.sv =====
// Stages 1 and 2: scaled vector terms, sector decision and active-vector term selection.
module svpwm_sector #(
	parameter int VECTOR_WIDTH = 16
) (
	input  logic                                          clk,
	input  svpwm_pkg::stage_adv_t                         adv,
	input  logic signed [VECTOR_WIDTH-1:0]                alpha,
	input  logic signed [VECTOR_WIDTH-1:0]                beta,
	output logic [VECTOR_WIDTH+svpwm_pkg::KFRAC-1:0]      xf_s2,
	output logic [VECTOR_WIDTH+svpwm_pkg::KFRAC-1:0]      xs_s2,
	output svpwm_pkg::sector_t                            sector_s2
);
	import svpwm_pkg::*;

	localparam int AW = VECTOR_WIDTH + KFRAC + 1;
	localparam logic signed [22:0] K1 = 23'(INV_SQRT3_K);
	localparam logic signed [22:0] K2 = 23'(TWO_INV_SQRT3_K);

	logic signed [AW-1:0] a_s1;
	logic signed [AW-1:0] b1_s1;
	logic signed [AW-1:0] b2_s1;

	logic signed [AW-1:0] nb1;
	logic signed [AW-1:0] amb;
	logic signed [AW-1:0] bma;
	logic signed [AW-1:0] apb;
	logic signed [AW-1:0] nab;
	logic signed [AW-1:0] nb2;
	logic signed [AW-1:0] tf;
	logic signed [AW-1:0] ts;
	logic                 aneg;
	logic                 bneg;
	sector_t              sec;

	always_ff @(posedge clk) begin
		if (adv.early) begin
			a_s1  <= AW'(alpha) <<< KFRAC;
			b1_s1 <= AW'(beta) * AW'(K1);
			b2_s1 <= AW'(beta) * AW'(K2);
		end
	end

	always_comb begin
		aneg = a_s1[AW-1];
		bneg = b1_s1[AW-1];
		nb1  = -b1_s1;
		amb  = a_s1 - b1_s1;
		bma  = b1_s1 - a_s1;
		apb  = a_s1 + b1_s1;
		nab  = -a_s1 - b1_s1;
		nb2  = -b2_s1;

		if (!bneg) begin
			if (!aneg) begin
				sec = (b1_s1 > a_s1) ? SEC_2 : SEC_1;
			end else begin
				sec = (nb1 > a_s1) ? SEC_3 : SEC_2;
			end
		end else begin
			if (!aneg) begin
				sec = (nb1 > a_s1) ? SEC_5 : SEC_6;
			end else begin
				sec = (b1_s1 > a_s1) ? SEC_4 : SEC_5;
			end
		end

		case (sec)
			SEC_1: begin
				tf = amb;
				ts = b2_s1;
			end
			SEC_2: begin
				tf = bma;
				ts = apb;
			end
			SEC_3: begin
				tf = b2_s1;
				ts = nab;
			end
			SEC_4: begin
				tf = nb2;
				ts = bma;
			end
			SEC_5: begin
				tf = nab;
				ts = amb;
			end
			default: begin
				tf = apb;
				ts = nb2;
			end
		endcase
	end

	// drop terms that are zero or negative
	always_ff @(posedge clk) begin
		if (adv.late) begin
			xf_s2     <= (!tf[AW-1] && (tf != '0)) ? tf[AW-2:0] : '0;
			xs_s2     <= (!ts[AW-1] && (ts != '0)) ? ts[AW-2:0] : '0;
			sector_s2 <= sec;
		end
	end

endmodule

// ===== hdl/svpwm_ontime.sv =====
// Stages 3 and 4: split product of one term with the half period, then truncating shift.
module svpwm_ontime #(
	parameter int VECTOR_WIDTH = 16,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic                                     clk,
	input  svpwm_pkg::stage_adv_t                    adv,
	input  logic [VECTOR_WIDTH+svpwm_pkg::KFRAC-1:0] x,
	input  logic [COUNT_WIDTH-1:0]                   h,
	output logic [COUNT_WIDTH:0]                     t_s4
);
	import svpwm_pkg::*;

	localparam int XW  = VECTOR_WIDTH + KFRAC;
	localparam int PHW = VECTOR_WIDTH + COUNT_WIDTH;
	localparam int PLW = KFRAC + COUNT_WIDTH;
	localparam int SW  = XW + COUNT_WIDTH;
	localparam int PS  = VECTOR_WIDTH - 1 + KFRAC;

	logic [PHW-1:0] phi_s3;
	logic [PLW-1:0] plo_s3;
	logic [SW-1:0]  prod;

	always_ff @(posedge clk) begin
		if (adv.early) begin
			phi_s3 <= PHW'(x[XW-1:KFRAC]) * PHW'(h);
			plo_s3 <= PLW'(x[KFRAC-1:0]) * PLW'(h);
		end
	end

	assign prod = {phi_s3, {KFRAC{1'b0}}} + SW'(plo_s3);

	always_ff @(posedge clk) begin
		if (adv.late) begin
			t_s4 <= prod[PS +: COUNT_WIDTH+1];
		end
	end

endmodule

// ===== hdl/svpwm_compare.sv =====
// Stages 5 and 6: zero-vector time, compare values, saturation and phase ordering.
module svpwm_compare #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  svpwm_pkg::stage_adv_t  adv,
	input  logic [COUNT_WIDTH:0]   tf,
	input  logic [COUNT_WIDTH:0]   ts,
	input  svpwm_pkg::sector_t     sector,
	input  logic [COUNT_WIDTH-1:0] h,
	output logic [COUNT_WIDTH-1:0] time_a_s6,
	output logic [COUNT_WIDTH-1:0] time_b_s6,
	output logic [COUNT_WIDTH-1:0] time_c_s6,
	output svpwm_pkg::sector_t     sector_s6
);
	import svpwm_pkg::*;

	localparam int SMW = COUNT_WIDTH + 2;
	localparam int CIW = COUNT_WIDTH + 3;

	logic [SMW-1:0]         sum;
	logic [COUNT_WIDTH-1:0] diff;

	logic [COUNT_WIDTH-1:0] z_s5;
	logic [COUNT_WIDTH:0]   tf_s5;
	logic [SMW-1:0]         sum_s5;
	sector_t                sec_s5;

	logic [CIW-1:0]         c1;
	logic [CIW-1:0]         c2;
	logic [COUNT_WIDTH-1:0] q0;
	logic [COUNT_WIDTH-1:0] q1;
	logic [COUNT_WIDTH-1:0] q2;

	assign sum  = SMW'(tf) + SMW'(ts);
	assign diff = h - sum[COUNT_WIDTH-1:0];

	// clamp the zero-vector time at zero under overmodulation
	always_ff @(posedge clk) begin
		if (adv.early) begin
			z_s5   <= (sum >= SMW'(h)) ? '0 : (diff >> 1);
			tf_s5  <= tf;
			sum_s5 <= sum;
			sec_s5 <= sector;
		end
	end

	always_comb begin
		c1 = CIW'(z_s5) + CIW'(tf_s5);
		c2 = CIW'(z_s5) + CIW'(sum_s5);
		q0 = z_s5;
		q1 = (|c1[CIW-1:COUNT_WIDTH]) ? '1 : c1[COUNT_WIDTH-1:0];
		q2 = (|c2[CIW-1:COUNT_WIDTH]) ? '1 : c2[COUNT_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv.late) begin
			sector_s6 <= sec_s5;
			case (sec_s5)
				SEC_1: begin
					time_a_s6 <= q0;
					time_b_s6 <= q1;
					time_c_s6 <= q2;
				end
				SEC_2: begin
					time_b_s6 <= q0;
					time_a_s6 <= q1;
					time_c_s6 <= q2;
				end
				SEC_3: begin
					time_b_s6 <= q0;
					time_c_s6 <= q1;
					time_a_s6 <= q2;
				end
				SEC_4: begin
					time_c_s6 <= q0;
					time_b_s6 <= q1;
					time_a_s6 <= q2;
				end
				SEC_5: begin
					time_c_s6 <= q0;
					time_a_s6 <= q1;
					time_b_s6 <= q2;
				end
				default: begin
					time_a_s6 <= q0;
					time_c_s6 <= q1;
					time_b_s6 <= q2;
				end
			endcase
		end
	end

endmodule

// ===== hdl/space_vector_pwm_timing_unit.sv =====
// Top level of the space vector PWM timing unit: handshake, half-period register, stages.
//
//   channel  dir  payload                          beat accepted when
//   cfg      in   half_period                      cfg.valid && cfg.ready (ready always high)
//   vec      in   alpha, beta                      vec.valid && vec.ready
//   pwm      out  time_a, time_b, time_c, sector   pwm.valid && pwm.ready
//
// One vector beat per cycle while the output is not stalled; a result is valid on pwm once
// it reaches the last stage register.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// squeeze out and new beats enter while a finished result waits at the output.
// Reset clears all stage valid bits and loads half_period with 4200.
module space_vector_pwm_timing_unit #(
	parameter int VECTOR_WIDTH = svpwm_pkg::VECTOR_WIDTH_DEF,
	parameter int COUNT_WIDTH  = svpwm_pkg::COUNT_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	svpwm_cfg_if.sink    cfg,
	svpwm_vec_if.sink    vec,
	svpwm_time_if.source pwm
);
	import svpwm_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] HP_RST = COUNT_WIDTH'(HALF_PERIOD_RST);
	localparam int XW = VECTOR_WIDTH + KFRAC;

	logic [COUNT_WIDTH-1:0] hp_q;
	logic [STAGES-1:0]      vld_s;
	logic [STAGES-1:0]      adv;

	stage_adv_t adv_sec;
	stage_adv_t adv_ont;
	stage_adv_t adv_cmp;

	logic [XW-1:0]          xf_s2;
	logic [XW-1:0]          xs_s2;
	sector_t                sector_s2;
	sector_t                sec_s3;
	sector_t                sec_s4;
	logic [COUNT_WIDTH:0]   tf_s4;
	logic [COUNT_WIDTH:0]   ts_s4;
	logic [COUNT_WIDTH-1:0] time_a_s6;
	logic [COUNT_WIDTH-1:0] time_b_s6;
	logic [COUNT_WIDTH-1:0] time_c_s6;
	sector_t                sector_s6;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= HP_RST;
		end else if (cfg.valid) begin
			hp_q <= cfg.half_period;
		end
	end

	always_comb begin
		adv[STAGES-1] = !vld_s[STAGES-1] || pwm.ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= (adv & {vld_s[STAGES-2:0], vec.valid}) | (~adv & vld_s);
		end
	end

	assign vec.ready = adv[0];

	assign adv_sec = '{early: adv[0], late: adv[1]};
	assign adv_ont = '{early: adv[2], late: adv[3]};
	assign adv_cmp = '{early: adv[4], late: adv[5]};

	svpwm_sector #(
		.VECTOR_WIDTH (VECTOR_WIDTH)
	) u_sector (
		.clk       (clk),
		.adv       (adv_sec),
		.alpha     (vec.alpha),
		.beta      (vec.beta),
		.xf_s2     (xf_s2),
		.xs_s2     (xs_s2),
		.sector_s2 (sector_s2)
	);

	svpwm_ontime #(
		.VECTOR_WIDTH (VECTOR_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_ontime_f (
		.clk  (clk),
		.adv  (adv_ont),
		.x    (xf_s2),
		.h    (hp_q),
		.t_s4 (tf_s4)
	);

	svpwm_ontime #(
		.VECTOR_WIDTH (VECTOR_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_ontime_s (
		.clk  (clk),
		.adv  (adv_ont),
		.x    (xs_s2),
		.h    (hp_q),
		.t_s4 (ts_s4)
	);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			sec_s3 <= sector_s2;
		end
		if (adv[3]) begin
			sec_s4 <= sec_s3;
		end
	end

	svpwm_compare #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_compare (
		.clk       (clk),
		.adv       (adv_cmp),
		.tf        (tf_s4),
		.ts        (ts_s4),
		.sector    (sec_s4),
		.h         (hp_q),
		.time_a_s6 (time_a_s6),
		.time_b_s6 (time_b_s6),
		.time_c_s6 (time_c_s6),
		.sector_s6 (sector_s6)
	);

	assign pwm.valid  = vld_s[STAGES-1];
	assign pwm.time_a = time_a_s6;
	assign pwm.time_b = time_b_s6;
	assign pwm.time_c = time_c_s6;
	assign pwm.sector = sector_s6;

endmodule
